>>> rtl/hqd_pkg.sv
`default_nettype none

package hqd_pkg;

    // Width of one converter reading and of the wrapping counters.
    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 32;

    // Width of every count and time field on the result port.
    localparam int OUT_BITS = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_A = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_A  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_B = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_B  = 3'd3;

    // Reset values of the threshold registers.
    localparam logic [SAMPLE_BITS-1:0] HIGH_RESET = SAMPLE_BITS'(2500);
    localparam logic [SAMPLE_BITS-1:0] LOW_RESET  = SAMPLE_BITS'(1500);

    // Effect of one level-pair transition on the position count.
    typedef enum logic [1:0] {
        QSTEP_ERR = 2'd0,
        QSTEP_INC = 2'd1,
        QSTEP_DEC = 2'd2
    } qstep_t;

    // 4x decode table, indexed by {old levels, new levels}.
    localparam qstep_t QUAD_TABLE [16] = '{
        QSTEP_ERR, QSTEP_INC, QSTEP_DEC, QSTEP_ERR,
        QSTEP_DEC, QSTEP_ERR, QSTEP_ERR, QSTEP_INC,
        QSTEP_INC, QSTEP_ERR, QSTEP_ERR, QSTEP_DEC,
        QSTEP_ERR, QSTEP_DEC, QSTEP_INC, QSTEP_ERR
    };

endpackage

`default_nettype wire

>>> rtl/hysteresis_quadrature_decoder.sv
// A sample is decoded in the cycle after its input transfer; its result is
// then loaded into the result register, which drives the result port, as soon
// as that register is empty or its result is being transferred out.
// Throughput: one sample per cycle while the result side keeps up; the input
// register still takes one more sample while a finished result waits.
// Reset (asynchronous, active low) clears levels, counters and the latched
// time, and loads the thresholds and the armed levels with 2500 and 1500.
`default_nettype none

module hysteresis_quadrature_decoder
    import hqd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [SAMPLE_BITS-1:0]  cfg_data,

    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    channel,
    input  wire logic [SAMPLE_BITS-1:0]  sample,
    input  wire logic [OUT_BITS-1:0]     time_now,

    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         event_res,
    output logic [1:0]                   levels,
    output logic signed [OUT_BITS-1:0]   position,
    output logic [OUT_BITS-1:0]          error_count,
    output logic [OUT_BITS-1:0]          a_events,
    output logic [OUT_BITS-1:0]          b_events,
    output logic [OUT_BITS-1:0]          event_time
);

    // Threshold registers written through the configuration port.
    logic [SAMPLE_BITS-1:0] high_a_reg;
    logic [SAMPLE_BITS-1:0] low_a_reg;
    logic [SAMPLE_BITS-1:0] high_b_reg;
    logic [SAMPLE_BITS-1:0] low_b_reg;

    // Input register: holds one accepted sample until it is decoded.
    logic                   s1_valid_reg;
    logic                   s1_channel_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [OUT_BITS-1:0]    s1_time_reg;

    // Decoder state. These registers change only when a result is loaded,
    // so together with event_res_reg they also form the result register.
    logic [SAMPLE_BITS-1:0] arm_high_reg [2];
    logic [SAMPLE_BITS-1:0] arm_low_reg  [2];
    logic [1:0]             levels_reg;
    logic [COUNT_BITS-1:0]  position_reg;
    logic [COUNT_BITS-1:0]  err_count_reg;
    logic [COUNT_BITS-1:0]  a_count_reg;
    logic [COUNT_BITS-1:0]  b_count_reg;
    logic [OUT_BITS-1:0]    event_time_reg;
    logic                   event_res_reg;
    logic                   out_valid_reg;

    logic                   load;
    logic [SAMPLE_BITS-1:0] cur_high;
    logic [SAMPLE_BITS-1:0] cur_low;
    logic                   rise;
    logic                   fall;
    logic                   crossing;
    logic [1:0]             chan_bit;
    logic [1:0]             levels_next;
    qstep_t                 qstep;

    // The decoded sample moves into the result register when that register
    // is empty or its result is being transferred out in this cycle.
    assign load     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || load;

    // Hysteresis comparator for the sample's channel. When both armed levels
    // are exceeded (high threshold set below the low one) the rising
    // crossing wins.
    assign cur_high = arm_high_reg[s1_channel_reg];
    assign cur_low  = arm_low_reg[s1_channel_reg];
    assign rise     = s1_sample_reg > cur_high;
    assign fall     = !rise && (s1_sample_reg < cur_low);
    assign crossing = rise || fall;
    assign chan_bit = s1_channel_reg ? 2'b10 : 2'b01;

    always_comb
    begin
        levels_next = levels_reg;
        if (rise)
        begin
            levels_next = levels_reg | chan_bit;
        end
        else if (fall)
        begin
            levels_next = levels_reg & ~chan_bit;
        end
    end

    // A crossing in the direction the level already has leaves the pair
    // unchanged; the table maps that, like a double change, to an error.
    assign qstep = QUAD_TABLE[{levels_reg, levels_next}];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_a_reg <= HIGH_RESET;
            low_a_reg  <= LOW_RESET;
            high_b_reg <= HIGH_RESET;
            low_b_reg  <= LOW_RESET;
        end
        else if (cfg_we)
        begin
            // A write changes only the level used at the next re-arm.
            unique case (cfg_index)
                CFG_HIGH_A: high_a_reg <= cfg_data;
                CFG_LOW_A:  low_a_reg  <= cfg_data;
                CFG_HIGH_B: high_b_reg <= cfg_data;
                CFG_LOW_B:  low_b_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_channel_reg <= channel;
            s1_sample_reg  <= sample;
            s1_time_reg    <= time_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_high_reg[0] <= HIGH_RESET;
            arm_high_reg[1] <= HIGH_RESET;
            arm_low_reg[0]  <= LOW_RESET;
            arm_low_reg[1]  <= LOW_RESET;
            levels_reg      <= 2'b00;
            position_reg    <= '0;
            err_count_reg   <= '0;
            a_count_reg     <= '0;
            b_count_reg     <= '0;
            event_time_reg  <= '0;
            event_res_reg   <= 1'b0;
        end
        else if (load)
        begin
            event_res_reg <= crossing;
            if (rise)
            begin
                // Disarm high, arm low from the channel's register.
                arm_high_reg[s1_channel_reg] <= '1;
                arm_low_reg[s1_channel_reg]  <= s1_channel_reg ? low_b_reg : low_a_reg;
            end
            else if (fall)
            begin
                arm_low_reg[s1_channel_reg]  <= '0;
                arm_high_reg[s1_channel_reg] <= s1_channel_reg ? high_b_reg : high_a_reg;
            end
            if (crossing)
            begin
                levels_reg     <= levels_next;
                event_time_reg <= s1_time_reg;
                if (s1_channel_reg)
                begin
                    b_count_reg <= b_count_reg + 1'b1;
                end
                else
                begin
                    a_count_reg <= a_count_reg + 1'b1;
                end
                unique case (qstep)
                    QSTEP_INC: position_reg  <= position_reg + 1'b1;
                    QSTEP_DEC: position_reg  <= position_reg - 1'b1;
                    default:   err_count_reg <= err_count_reg + 1'b1;
                endcase
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = event_res_reg;
    assign levels      = levels_reg;
    assign position    = OUT_BITS'(signed'(position_reg));
    assign error_count = OUT_BITS'(err_count_reg);
    assign a_events    = OUT_BITS'(a_count_reg);
    assign b_events    = OUT_BITS'(b_count_reg);
    assign event_time  = event_time_reg;

    // A sample that crosses no level leaves levels and decode counters alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && !crossing) |=> ($stable(levels_reg) && $stable(position_reg)
                                 && $stable(err_count_reg)))
        else $error("state changed on a sample without crossing");

    // Every crossing bumps exactly one of the two channel counters.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && crossing) |=> (($past(a_count_reg) != a_count_reg)
                                != ($past(b_count_reg) != b_count_reg)))
        else $error("crossing did not bump exactly one channel counter");

    // Every crossing moves the position or counts an error, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && crossing) |=> (($past(position_reg) != position_reg)
                                != ($past(err_count_reg) != err_count_reg)))
        else $error("crossing did not update exactly one of position and errors");

    // After a rising crossing on channel A, the high level of A is disarmed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && rise && !s1_channel_reg) |=> (arm_high_reg[0] == '1))
        else $error("channel A high level still armed after rising crossing");

endmodule

`default_nettype wire

>>> tb/sv/hqd_tb_pkg.sv
package hqd_tb_pkg;

    import hqd_pkg::*;

    // One result transfer, field by field.
    typedef struct packed {
        logic                event_res;
        logic [1:0]          levels;
        logic [OUT_BITS-1:0] position;
        logic [OUT_BITS-1:0] error_count;
        logic [OUT_BITS-1:0] a_events;
        logic [OUT_BITS-1:0] b_events;
        logic [OUT_BITS-1:0] event_time;
    } decoder_result_t;

    class quad_tracker;

        // Threshold registers and the levels currently armed, index 0 = A, 1 = B.
        logic [SAMPLE_BITS-1:0] high_reg [2];
        logic [SAMPLE_BITS-1:0] low_reg [2];
        logic [SAMPLE_BITS-1:0] armed_high [2];
        logic [SAMPLE_BITS-1:0] armed_low [2];

        logic [1:0]            lvl;
        logic [COUNT_BITS-1:0] pos;
        logic [COUNT_BITS-1:0] errs;
        logic [COUNT_BITS-1:0] a_cnt;
        logic [COUNT_BITS-1:0] b_cnt;
        logic [OUT_BITS-1:0]   t_last;

        decoder_result_t expected_results [$];

        int mismatches;
        int samples_noted;
        int crossings_noted;
        int results_checked;

        function new();
            for (int i = 0; i < 2; i++) begin
                high_reg[i]   = HIGH_RESET;
                low_reg[i]    = LOW_RESET;
                armed_high[i] = HIGH_RESET;
                armed_low[i]  = LOW_RESET;
            end
            lvl             = '0;
            pos             = '0;
            errs            = '0;
            a_cnt           = '0;
            b_cnt           = '0;
            t_last          = '0;
            mismatches      = 0;
            samples_noted   = 0;
            crossings_noted = 0;
            results_checked = 0;
        endfunction

        // Unknown indexes leave every register alone.
        function void write_register(logic [CFG_IDX_BITS-1:0] index,
                                     logic [SAMPLE_BITS-1:0] value);
            case (index)
                CFG_HIGH_A: high_reg[0] = value;
                CFG_LOW_A:  low_reg[0]  = value;
                CFG_HIGH_B: high_reg[1] = value;
                CFG_LOW_B:  low_reg[1]  = value;
                default:    ;
            endcase
        endfunction

        function void note_sample(logic ch, logic [SAMPLE_BITS-1:0] s,
                                  logic [OUT_BITS-1:0] t);
            logic [1:0]      prev_lvl;
            logic [1:0]      next_lvl;
            logic [1:0]      prev_phase;
            logic [1:0]      next_phase;
            logic [1:0]      turn;
            logic            crossed;
            int              idx;
            decoder_result_t exp_item;
            idx      = ch;
            prev_lvl = lvl;
            next_lvl = lvl;
            crossed  = 1'b0;
            // A rising crossing is tested first, so it wins if both apply.
            if (s > armed_high[idx]) begin
                crossed         = 1'b1;
                armed_high[idx] = '1;
                armed_low[idx]  = low_reg[idx];
                next_lvl[idx]   = 1'b1;
            end
            else if (s < armed_low[idx]) begin
                crossed         = 1'b1;
                armed_low[idx]  = '0;
                armed_high[idx] = high_reg[idx];
                next_lvl[idx]   = 1'b0;
            end
            if (crossed) begin
                t_last = t;
                if (ch)
                    b_cnt = b_cnt + 1'b1;
                else
                    a_cnt = a_cnt + 1'b1;
                // The Gray-coded level pair maps onto a quarter-turn phase; one
                // step forward or back moves the position, anything else is an error.
                prev_phase = {prev_lvl[1], prev_lvl[1] ^ prev_lvl[0]};
                next_phase = {next_lvl[1], next_lvl[1] ^ next_lvl[0]};
                turn       = next_phase - prev_phase;
                if (turn == 2'd1)
                    pos = pos + 1'b1;
                else if (turn == 2'd3)
                    pos = pos - 1'b1;
                else
                    errs = errs + 1'b1;
                lvl = next_lvl;
                crossings_noted++;
            end
            exp_item.event_res   = crossed;
            exp_item.levels      = lvl;
            exp_item.position    = OUT_BITS'(signed'(pos));
            exp_item.error_count = OUT_BITS'(errs);
            exp_item.a_events    = OUT_BITS'(a_cnt);
            exp_item.b_events    = OUT_BITS'(b_cnt);
            exp_item.event_time  = t_last;
            expected_results.push_back(exp_item);
            samples_noted++;
        endfunction

        function void compare_field(string field, logic [OUT_BITS-1:0] want,
                                    logic [OUT_BITS-1:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(decoder_result_t got);
            decoder_result_t want;
            results_checked++;
            if (expected_results.size() == 0) begin
                $error("result transfer with no sample outstanding");
                mismatches++;
            end
            else begin
                want = expected_results.pop_front();
                compare_field("event_res", OUT_BITS'(want.event_res),
                              OUT_BITS'(got.event_res));
                compare_field("levels", OUT_BITS'(want.levels), OUT_BITS'(got.levels));
                compare_field("position", want.position, got.position);
                compare_field("error_count", want.error_count, got.error_count);
                compare_field("a_events", want.a_events, got.a_events);
                compare_field("b_events", want.b_events, got.b_events);
                compare_field("event_time", want.event_time, got.event_time);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

    endclass

endpackage

>>> tb/sv/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import hqd_pkg::*;
    import hqd_tb_pkg::*;

    // Largest converter reading.
    localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;

    // Samples per random phase; the threshold set changes halfway through.
    localparam int ITEMS_PER_PHASE = 400;

    // Cycles allowed after the last result before a register is written or
    // the run ends.
    localparam int DRAIN_CYCLES = 4;

    // Cycles in a row without any transfer before the run is declared hung.
    // A receiver that is ready one cycle in five makes long gaps very unlikely,
    // so this is generous.
    localparam int WATCHDOG_LIMIT = 2000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;

    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [SAMPLE_BITS-1:0]  cfg_data = '0;

    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    channel = 1'b0;
    logic [SAMPLE_BITS-1:0]  sample = '0;
    logic [OUT_BITS-1:0]     time_now = '0;

    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    event_res;
    logic [1:0]              levels;
    logic signed [OUT_BITS-1:0] position;
    logic [OUT_BITS-1:0]     error_count;
    logic [OUT_BITS-1:0]     a_events;
    logic [OUT_BITS-1:0]     b_events;
    logic [OUT_BITS-1:0]     event_time;

    quad_tracker     tracker;
    decoder_result_t observed;

    // Percentages of cycles in which the sender holds back and the receiver
    // stalls. They change from phase to phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // The level pair the stimulus is steering toward and the direction of the
    // simulated rotation.
    logic [1:0] gen_level = 2'b00;
    logic       walk_forward = 1'b1;

    int quiet_cycles = 0;

    hysteresis_quadrature_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .channel     (channel),
        .sample      (sample),
        .time_now    (time_now),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_res   (event_res),
        .levels      (levels),
        .position    (position),
        .error_count (error_count),
        .a_events    (a_events),
        .b_events    (b_events),
        .event_time  (event_time)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Monitor. Everything the block drives changes only after the edge, so the
    // values read here are the ones the transfers at this edge used. A sample
    // transfer is recorded before a result transfer is checked at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                tracker.note_sample(channel, sample, time_now);
            end
            if (out_valid && out_ready)
            begin
                observed.event_res   = event_res;
                observed.levels      = levels;
                observed.position    = position;
                observed.error_count = error_count;
                observed.a_events    = a_events;
                observed.b_events    = b_events;
                observed.event_time  = event_time;
                tracker.check_result(observed);
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: counts cycles with neither a sample nor a result transfer.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready))
            begin
                quiet_cycles++;
            end
            else
            begin
                quiet_cycles = 0;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Offers one sample and returns at the edge where it transfers. Valid is
    // left high so that a sample that follows at once keeps it high; it is
    // lowered only when the sender holds back or the stream stops.
    task automatic send_sample(input logic ch, input logic [SAMPLE_BITS-1:0] s,
                               input logic [OUT_BITS-1:0] t);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        channel  <= ch;
        sample   <= s;
        time_now <= t;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stops the stream and waits until every result has come back, then lets
    // the block settle for a few more cycles. The first wait lets the monitor
    // record a transfer made at the edge this task was called on.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write; the write enable stays high so that writes can
    // follow one another on consecutive cycles.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] index,
                             input logic [SAMPLE_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        tracker.write_register(index, value);
    endtask

    // Writes all four thresholds while the block is idle, plus one write to an
    // index past the last register, which must change nothing.
    task automatic set_thresholds(input int ha, input int la, input int hb, input int lb);
        wait_drained();
        write_reg(CFG_HIGH_A, SAMPLE_BITS'(ha));
        write_reg(CFG_LOW_A, SAMPLE_BITS'(la));
        write_reg(CFG_HIGH_B, SAMPLE_BITS'(hb));
        write_reg(CFG_LOW_B, SAMPLE_BITS'(lb));
        write_reg(CFG_IDX_BITS'($urandom_range(7, 4)), SAMPLE_BITS'($urandom));
        cfg_we <= 1'b0;
    endtask

    // A sensible hysteresis band per channel: the low level sits below the
    // high one and above zero, so both crossings stay reachable.
    task automatic set_random_thresholds();
        int ha;
        int la;
        int hb;
        int lb;
        ha = $urandom_range(SAMPLE_MAX - 1, SAMPLE_MAX / 4);
        la = $urandom_range(ha - 1, 1);
        hb = $urandom_range(SAMPLE_MAX - 1, SAMPLE_MAX / 4);
        lb = $urandom_range(hb - 1, 1);
        set_thresholds(ha, la, hb, lb);
    endtask

    // Most samples step the encoder through its Gray sequence, one channel
    // crossing at a time, now and then reversing. The rest are readings inside
    // the hysteresis band set in the threshold registers, and plain noise.
    task automatic send_random_item();
        int                     pick;
        int                     h;
        int                     l;
        logic                   ch;
        logic [SAMPLE_BITS-1:0] s;
        pick = $urandom_range(99);
        if (pick < 65)
        begin
            if ($urandom_range(9) == 0)
            begin
                walk_forward = ~walk_forward;
            end
            // Forward runs 00, 01, 11, 10: channel A moves when the bits agree.
            if (walk_forward)
                ch = (gen_level[0] == gen_level[1]) ? 1'b0 : 1'b1;
            else
                ch = (gen_level[0] == gen_level[1]) ? 1'b1 : 1'b0;
            h = tracker.high_reg[ch];
            l = tracker.low_reg[ch];
            if (!gen_level[ch])
                s = (h >= SAMPLE_MAX) ? '1 : SAMPLE_BITS'($urandom_range(SAMPLE_MAX, h + 1));
            else
                s = (l == 0) ? '0 : SAMPLE_BITS'($urandom_range(l - 1, 0));
            gen_level[ch] = ~gen_level[ch];
        end
        else if (pick < 85)
        begin
            ch = $urandom_range(1);
            h  = tracker.high_reg[ch];
            l  = tracker.low_reg[ch];
            if (l <= h)
                s = SAMPLE_BITS'($urandom_range(h, l));
            else
                s = SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
        end
        else
        begin
            ch = $urandom_range(1);
            s  = SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
        end
        send_sample(ch, s, $urandom);
    endtask

    initial
    begin
        tracker = new();
        send_idle_pct = 13;
        recv_idle_pct = 79;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset thresholds. Both channels start low with
        // both levels armed, so a low reading is a falling crossing while
        // already low and counts as an error.
        send_sample(1'b0, '0, '0);
        send_sample(1'b1, '0, '1);
        send_sample(1'b0, '1, $urandom);
        // The high level of A is disarmed now: even full scale does nothing.
        send_sample(1'b0, '1, $urandom);
        // Readings equal to an armed level do not cross it.
        send_sample(1'b0, SAMPLE_BITS'(1500), $urandom);
        send_sample(1'b1, SAMPLE_BITS'(2500), $urandom);
        // The forward turn is completed, then the walk steps back.
        send_sample(1'b1, SAMPLE_BITS'(2501), $urandom);
        send_sample(1'b0, SAMPLE_BITS'(1499), $urandom);
        send_sample(1'b1, '0, $urandom);
        send_sample(1'b1, '1, $urandom);
        send_sample(1'b0, SAMPLE_BITS'(2501), $urandom);

        // Extreme and inverted thresholds. The levels armed right now stay in
        // force; the new values only take effect at the next re-arm.
        set_thresholds(0, SAMPLE_MAX, SAMPLE_MAX, 0);
        send_sample(1'b0, SAMPLE_BITS'(1000), $urandom);
        send_sample(1'b0, '0, $urandom);
        send_sample(1'b0, SAMPLE_BITS'(1), $urandom);
        send_sample(1'b0, SAMPLE_BITS'(SAMPLE_MAX - 1), $urandom);
        send_sample(1'b1, SAMPLE_BITS'(100), $urandom);
        // With a high level of full scale and a low level of zero, B is stuck.
        send_sample(1'b1, '1, $urandom);
        send_sample(1'b1, '0, $urandom);
        send_sample(1'b0, '1, '0);

        // Random phases: sender mostly busy with a slow receiver, then the
        // reverse, then both at full speed. The sender pauses for a full drain
        // when the thresholds change halfway through each phase.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 13;
                    recv_idle_pct = 79;
                end
                1:
                begin
                    send_idle_pct = 79;
                    recv_idle_pct = 13;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            set_random_thresholds();
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == ITEMS_PER_PHASE / 2)
                begin
                    set_random_thresholds();
                end
                send_random_item();
            end
        end

        wait_drained();

        $display("Checked %0d samples, %0d of them threshold crossings, against %0d result transfers.",
                 tracker.samples_noted, tracker.crossings_noted, tracker.results_checked);
        $display("Thresholds ran at reset values, extremes and six random bands under three stall mixes.");
        if (tracker.mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
